### hw/rtl/delimited_frame_length_checker_top_macros.svh
// assertion helpers for the frame length checker
// both expect signals named clk and rst_n in the enclosing module
`ifndef DELIMITED_FRAME_LENGTH_CHECKER_TOP_MACROS_SVH
`define DELIMITED_FRAME_LENGTH_CHECKER_TOP_MACROS_SVH

// same-cycle implication
`define DFLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dflc same-cycle check failed");

// next-cycle implication
`define DFLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dflc next-cycle check failed");

`endif

### hw/rtl/dflc_pkg.sv
package dflc_pkg;

  localparam int LENGTH_OFFSET   = 6;
  localparam int LENGTH_DIGITS   = 4;
  localparam int FIELD_END       = LENGTH_OFFSET + LENGTH_DIGITS;
  localparam int MIN_FRAME_BYTES = 10;
  localparam int COUNT_CAP       = 10000;

  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 14;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 8;
  // wide enough for cap * 10 + 9
  localparam int ACC_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_START_DELIM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_DELIM   = 8'd1;

  localparam logic [BYTE_W-1:0] START_DELIM_RST = 8'h2A;
  localparam logic [BYTE_W-1:0] END_DELIM_RST   = 8'h23;

  typedef enum logic [STATUS_W-1:0] {
    ST_DROPPED  = 3'd0,
    ST_PAYLOAD  = 3'd1,
    ST_GOOD     = 3'd2,
    ST_SHORT    = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_RESTART  = 3'd5
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  byte_index;
    logic [CNT_W-1:0]  frame_length;
  } result_t;

endpackage

### hw/rtl/dflc_intf.sv
interface dflc_in_if;
  logic                        valid;
  logic                        ready;
  logic [dflc_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dflc_out_if;
  logic                          valid;
  logic                          ready;
  logic [dflc_pkg::STATUS_W-1:0] status;
  logic [dflc_pkg::BYTE_W-1:0]   data_byte;
  logic [dflc_pkg::CNT_W-1:0]    byte_index;
  logic [dflc_pkg::CNT_W-1:0]    frame_length;

  modport source (output valid, output status, output data_byte, output byte_index,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input data_byte, input byte_index,
                  input frame_length, output ready);
endinterface

interface dflc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dflc_pkg::CFG_IDX_W-1:0] idx;
  logic [dflc_pkg::BYTE_W-1:0]    wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

### hw/rtl/dflc_frame_core.sv
module dflc_frame_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [dflc_pkg::BYTE_W-1:0] rx_byte,
  input  logic [dflc_pkg::BYTE_W-1:0] start_delim,
  input  logic [dflc_pkg::BYTE_W-1:0] end_delim,
  output dflc_pkg::result_t           res
);

  logic                       in_frame_r, in_frame_nxt;
  logic [dflc_pkg::CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [dflc_pkg::CNT_W-1:0] decl_len_r, decl_len_nxt;
  logic                       len_bad_r, len_bad_nxt;

  logic                       in_field;
  logic                       is_digit;
  logic [dflc_pkg::ACC_W-1:0] acc;
  dflc_pkg::status_t          verdict;

  assign in_field = (byte_count_r >= dflc_pkg::CNT_W'(dflc_pkg::LENGTH_OFFSET)) &&
                    (byte_count_r <  dflc_pkg::CNT_W'(dflc_pkg::FIELD_END));
  assign is_digit = rx_byte inside {[8'h30:8'h39]};
  assign acc = dflc_pkg::ACC_W'(decl_len_r) * dflc_pkg::ACC_W'(10) +
               dflc_pkg::ACC_W'(rx_byte - 8'h30);

  // judgement at the end delimiter
  always_comb begin
    if (byte_count_r < dflc_pkg::CNT_W'(dflc_pkg::MIN_FRAME_BYTES)) begin
      verdict = dflc_pkg::ST_SHORT;
    end else if (len_bad_r ||
                 (byte_count_r < dflc_pkg::CNT_W'(dflc_pkg::FIELD_END)) ||
                 (decl_len_r != byte_count_r)) begin
      verdict = dflc_pkg::ST_MISMATCH;
    end else begin
      verdict = dflc_pkg::ST_GOOD;
    end
  end

  always_comb begin
    in_frame_nxt   = in_frame_r;
    byte_count_nxt = byte_count_r;
    decl_len_nxt   = decl_len_r;
    len_bad_nxt    = len_bad_r;
    res            = '{status: dflc_pkg::ST_DROPPED, data_byte: '0,
                       byte_index: '0, frame_length: '0};
    if (!in_frame_r) begin
      if (rx_byte == start_delim) begin
        in_frame_nxt   = 1'b1;
        byte_count_nxt = '0;
        decl_len_nxt   = '0;
        len_bad_nxt    = 1'b0;
      end
    end else if (rx_byte == end_delim) begin
      res.status       = verdict;
      res.frame_length = byte_count_r;
      in_frame_nxt     = 1'b0;
      byte_count_nxt   = '0;
      decl_len_nxt     = '0;
      len_bad_nxt      = 1'b0;
    end else if (rx_byte == start_delim) begin
      res.status       = dflc_pkg::ST_RESTART;
      res.frame_length = byte_count_r;
      byte_count_nxt   = '0;
      decl_len_nxt     = '0;
      len_bad_nxt      = 1'b0;
    end else begin
      res.status     = dflc_pkg::ST_PAYLOAD;
      res.data_byte  = rx_byte;
      res.byte_index = byte_count_r;
      if (in_field) begin
        if (is_digit) begin
          if (acc > dflc_pkg::ACC_W'(dflc_pkg::COUNT_CAP)) begin
            decl_len_nxt = dflc_pkg::CNT_W'(dflc_pkg::COUNT_CAP);
          end else begin
            decl_len_nxt = acc[dflc_pkg::CNT_W-1:0];
          end
        end else begin
          len_bad_nxt = 1'b1;
        end
      end
      if (byte_count_r < dflc_pkg::CNT_W'(dflc_pkg::COUNT_CAP)) begin
        byte_count_nxt = byte_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      byte_count_r <= '0;
      decl_len_r   <= '0;
      len_bad_r    <= 1'b0;
    end else if (step) begin
      in_frame_r   <= in_frame_nxt;
      byte_count_r <= byte_count_nxt;
      decl_len_r   <= decl_len_nxt;
      len_bad_r    <= len_bad_nxt;
    end
  end

endmodule

### hw/rtl/delimited_frame_length_checker_top.sv
// an accepted input transaction passes the input register, then the result register, to reach out_ch
// throughput: one byte per cycle, sustained while out_ch.ready stays high
// one result transaction per input transaction, in order
// reset (rst_n low, synchronous): pipeline emptied, hunting for a start
// delimiter, counters cleared, delimiters back to '*' and '#'
`include "delimited_frame_length_checker_top_macros.svh"

module delimited_frame_length_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  dflc_in_if.sink     in_ch,
  dflc_out_if.source  out_ch,
  dflc_cfg_if.sink    cfg_ch
);

  // delimiter registers; the user must write them only while the pipeline is idle, the block does not enforce it
  logic [dflc_pkg::BYTE_W-1:0] start_delim_r;
  logic [dflc_pkg::BYTE_W-1:0] end_delim_r;

  // input register stage
  logic                        in_valid_r;
  logic [dflc_pkg::BYTE_W-1:0] in_byte_r;

  // result register stage
  logic                        out_valid_r;
  dflc_pkg::result_t           out_res_r;

  logic                        out_adv;
  logic                        in_take;
  dflc_pkg::result_t           core_res;

  // result register may load when empty or being drained this cycle
  assign out_adv = !out_valid_r || out_ch.ready;
  // input register may load when empty or moving into the result register
  assign in_ch.ready = !in_valid_r || out_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  // config writes; indexes beyond the register list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delim_r <= dflc_pkg::START_DELIM_RST;
      end_delim_r   <= dflc_pkg::END_DELIM_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        dflc_pkg::REG_START_DELIM: start_delim_r <= cfg_ch.wdata;
        dflc_pkg::REG_END_DELIM:   end_delim_r   <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // stage 1: capture the received byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // frame state and per-byte decision; state moves only when the byte leaves stage 1
  dflc_frame_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_valid_r && out_adv),
    .rx_byte     (in_byte_r),
    .start_delim (start_delim_r),
    .end_delim   (end_delim_r),
    .res         (core_res)
  );

  // stage 2: result register, holds while out_ch stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.data_byte    = out_res_r.data_byte;
  assign out_ch.byte_index   = out_res_r.byte_index;
  assign out_ch.frame_length = out_res_r.frame_length;

  // a byte leaving stage 1 always shows up as a result next cycle
  `DFLC_ASSERT_NEXT(a_stage_moves, in_valid_r && out_adv, out_valid_r)
  // payload results never carry a frame length
  `DFLC_ASSERT_NOW(a_payload_no_len,
                   out_valid_r && out_res_r.status == dflc_pkg::ST_PAYLOAD,
                   out_res_r.frame_length == '0)
  // a good frame is never shorter than the minimum
  `DFLC_ASSERT_NOW(a_good_min_len,
                   out_valid_r && out_res_r.status == dflc_pkg::ST_GOOD,
                   out_res_r.frame_length >= dflc_pkg::CNT_W'(dflc_pkg::MIN_FRAME_BYTES))
  // byte indexes stay within the saturation cap
  `DFLC_ASSERT_NOW(a_index_cap, out_valid_r,
                   out_res_r.byte_index <= dflc_pkg::CNT_W'(dflc_pkg::COUNT_CAP))

endmodule

### verif/tb_delimited_frame_length_checker_top.sv
`timescale 1ns / 1ps

module tb_delimited_frame_length_checker_top;

  // generous: the slowest legal run stays well below this
  localparam int CYCLE_LIMIT = 400000;
  // unmapped register index, writes to it must be ignored
  localparam logic [dflc_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'hFF;
  localparam logic [dflc_pkg::BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [dflc_pkg::BYTE_W-1:0] ASCII_NINE = 8'h39;
  // delimiter value used for both registers in the equal-delimiter test
  localparam logic [dflc_pkg::BYTE_W-1:0] SHARED_DELIM = 8'h55;

  logic clk;
  logic rst_n;

  dflc_in_if  in_if ();
  dflc_out_if out_if ();
  dflc_cfg_if cfg_if ();

  delimited_frame_length_checker_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // delimiter registers as the block should hold them
  logic [dflc_pkg::BYTE_W-1:0] cur_start;
  logic [dflc_pkg::BYTE_W-1:0] cur_end;

  // frame tracking state mirrored from the block
  logic                       trk_in_frame;
  logic [dflc_pkg::CNT_W-1:0] trk_count;
  logic [dflc_pkg::CNT_W-1:0] trk_declared;
  logic                       trk_bad_field;

  // results owed by the block, oldest first
  dflc_pkg::result_t awaited_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;
  int error_count;
  int results_checked;
  int counted_items;
  int cycle_count;
  int status_tally[6];

  // expected result for one accepted byte; advances the tracked frame state
  function automatic dflc_pkg::result_t classify_byte(input logic [dflc_pkg::BYTE_W-1:0] b);
    dflc_pkg::result_t r;
    int                acc;
    r = '0;
    r.status = dflc_pkg::ST_DROPPED;
    if (!trk_in_frame) begin
      // hunting: only a start delimiter matters, and it is dropped too
      if (b == cur_start) begin
        trk_in_frame = 1'b1;
        {trk_count, trk_declared, trk_bad_field} = '0;
      end
    end else if (b == cur_end) begin
      // end delimiter wins over start when both registers are equal
      if (trk_count < dflc_pkg::MIN_FRAME_BYTES) begin
        r.status = dflc_pkg::ST_SHORT;
      end else if (trk_bad_field || trk_count < dflc_pkg::FIELD_END ||
                   trk_declared != trk_count) begin
        r.status = dflc_pkg::ST_MISMATCH;
      end else begin
        r.status = dflc_pkg::ST_GOOD;
      end
      r.frame_length = trk_count;
      trk_in_frame = 1'b0;
      {trk_count, trk_declared, trk_bad_field} = '0;
    end else if (b == cur_start) begin
      // abandon the partial frame, stay in a frame
      r.status = dflc_pkg::ST_RESTART;
      r.frame_length = trk_count;
      {trk_count, trk_declared, trk_bad_field} = '0;
    end else begin
      r.status     = dflc_pkg::ST_PAYLOAD;
      r.data_byte  = b;
      r.byte_index = trk_count;
      if (trk_count >= dflc_pkg::LENGTH_OFFSET && trk_count < dflc_pkg::FIELD_END) begin
        if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
          acc = int'(trk_declared) * 10 + int'(b - ASCII_ZERO);
          trk_declared = (acc > dflc_pkg::COUNT_CAP) ?
                         dflc_pkg::CNT_W'(dflc_pkg::COUNT_CAP) : dflc_pkg::CNT_W'(acc);
        end else begin
          trk_bad_field = 1'b1;
        end
      end
      if (trk_count < dflc_pkg::COUNT_CAP) trk_count = trk_count + 1'b1;
    end
    return r;
  endfunction

  // random byte that is neither delimiter
  function automatic logic [dflc_pkg::BYTE_W-1:0] free_byte();
    logic [dflc_pkg::BYTE_W-1:0] b;
    do b = dflc_pkg::BYTE_W'($urandom_range(255)); while (b == cur_start || b == cur_end);
    return b;
  endfunction

  // offer one byte, record what it should produce once the block takes it
  task automatic send_byte(input logic [dflc_pkg::BYTE_W-1:0] b);
    dflc_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.rx_byte = b;
    do @(posedge clk); while (!in_if.ready);
    r = classify_byte(b);
    awaited_results.push_back(r);
    status_tally[r.status]++;
    if (r.status != dflc_pkg::ST_DROPPED) counted_items++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_until_drained();
    in_if.valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input logic [dflc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dflc_pkg::BYTE_W-1:0] val);
    wait_until_drained();
    cfg_if.valid = 1'b1;
    cfg_if.idx   = idx;
    cfg_if.wdata = val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      dflc_pkg::REG_START_DELIM: cur_start = val;
      dflc_pkg::REG_END_DELIM:   cur_end   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // start delimiter, then len payload bytes carrying decl as ascii digits in the
  // length field; the byte at bad_pos (if any) is a non-digit
  task automatic send_frame_body(input int len, input int decl, input int bad_pos);
    logic [dflc_pkg::BYTE_W-1:0] b;
    int                          divisor;
    send_byte(cur_start);
    for (int pos = 0; pos < len; pos++) begin
      if (pos == bad_pos) begin
        do b = dflc_pkg::BYTE_W'($urandom_range(255));
        while ((b >= ASCII_ZERO && b <= ASCII_NINE) || b == cur_start || b == cur_end);
      end else if (pos >= dflc_pkg::LENGTH_OFFSET && pos < dflc_pkg::FIELD_END) begin
        divisor = 1;
        repeat (dflc_pkg::FIELD_END - 1 - pos) divisor *= 10;
        b = ASCII_ZERO + dflc_pkg::BYTE_W'((decl / divisor) % 10);
      end else begin
        b = free_byte();
      end
      send_byte(b);
    end
  endtask

  // mostly well-formed frames with random content, some broken ones and noise
  task automatic send_random_frame();
    int pick;
    int len;
    int decl;
    int bad_pos;
    pick    = $urandom_range(99);
    bad_pos = -1;
    len     = ($urandom_range(19) == 0) ? $urandom_range(41, 150) :
                                          $urandom_range(dflc_pkg::FIELD_END, 40);
    decl    = len;
    if (pick < 45) begin
      // good frame
    end else if (pick < 60) begin
      // declared length off by one or arbitrary
      decl = ($urandom_range(1) == 1) ? $urandom_range(9999) : len + 1 - 2 * $urandom_range(1);
    end else if (pick < 70) begin
      bad_pos = $urandom_range(dflc_pkg::LENGTH_OFFSET, dflc_pkg::FIELD_END - 1);
    end else if (pick < 80) begin
      len  = $urandom_range(dflc_pkg::MIN_FRAME_BYTES - 1);
      decl = $urandom_range(9999);
    end else if (pick < 88) begin
      // partial frame, abandoned by the start of the next one
      send_frame_body($urandom_range(15), $urandom_range(9999), -1);
    end else begin
      // line noise between frames, stray end delimiters included
      repeat ($urandom_range(1, 6)) begin
        send_byte(($urandom_range(2) == 0) ? cur_end : dflc_pkg::BYTE_W'($urandom_range(255)));
      end
      return;
    end
    send_frame_body(len, decl, bad_pos);
    send_byte(cur_end);
  endtask

  task automatic test_random_frames(input int n);
    int goal;
    goal = counted_items + n;
    while (counted_items < goal) send_random_frame();
  endtask

  // hand-picked sequences under the reset delimiters '*' and '#'
  task automatic test_directed_frames();
    // hunting: extremes and a stray end are dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_string("#");
    // empty frame is too short
    send_string("*#");
    // restart after one byte, then a good frame whose field says 10
    send_string("*A*");
    send_byte(8'h00);
    send_string("BCDEF0010#");
    // non-digit just above '9' in the length field
    send_string("*abcdef001:#");
    // one-byte frame is too short
    send_string("*");
    send_byte(8'hFF);
    send_string("#");
  endtask

  // one byte value both opens and closes
  task automatic test_equal_delimiters();
    write_reg(dflc_pkg::REG_START_DELIM, SHARED_DELIM);
    write_reg(dflc_pkg::REG_END_DELIM, SHARED_DELIM);
    send_byte(SHARED_DELIM);
    send_byte(SHARED_DELIM);
    send_frame_body(dflc_pkg::MIN_FRAME_BYTES, dflc_pkg::MIN_FRAME_BYTES, -1);
    send_byte(SHARED_DELIM);
    repeat (15) send_random_frame();
  endtask

  task automatic test_extreme_delimiters();
    write_reg(dflc_pkg::REG_START_DELIM, 8'h00);
    write_reg(dflc_pkg::REG_END_DELIM, 8'hFF);
    test_random_frames(120);
    write_reg(dflc_pkg::REG_START_DELIM, 8'hFF);
    write_reg(dflc_pkg::REG_END_DELIM, 8'h00);
    test_random_frames(120);
  endtask

  task automatic test_random_delimiters();
    logic [dflc_pkg::BYTE_W-1:0] s;
    logic [dflc_pkg::BYTE_W-1:0] e;
    s = dflc_pkg::BYTE_W'($urandom_range(255));
    do e = dflc_pkg::BYTE_W'($urandom_range(255)); while (e == s);
    write_reg(REG_SPARE, 8'hA5);
    write_reg(dflc_pkg::REG_START_DELIM, s);
    write_reg(dflc_pkg::REG_END_DELIM, e);
    test_random_frames(150);
  endtask

  // receiver holds off while bytes keep coming, then the sender waits it out
  task automatic test_backpressure();
    recv_hold_cycles = 120;
    repeat (6) send_random_frame();
    wait_until_drained();
    test_random_frames(60);
  endtask

  // largest declared length the field can carry, far above the counted bytes
  task automatic test_max_declared_length();
    write_reg(dflc_pkg::REG_START_DELIM, dflc_pkg::START_DELIM_RST);
    write_reg(dflc_pkg::REG_END_DELIM, dflc_pkg::END_DELIM_RST);
    send_string("*ABCDEF9999#");
    send_frame_body(40, 9999, -1);
    send_byte(cur_end);
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    error_count++;
  endtask

  // result side: ready toggles at the falling edge, long hold-offs counted here
  initial begin : receiver
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_cycles > 0) begin
        out_if.ready = 1'b0;
        recv_hold_cycles--;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare every result transaction with the oldest owed one
  always @(posedge clk) begin : result_check
    dflc_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual status %0d",
                 $time, out_if.status);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (out_if.status !== want.status)
          report_mismatch("status", want.status, out_if.status);
        if (out_if.data_byte !== want.data_byte)
          report_mismatch("data_byte", want.data_byte, out_if.data_byte);
        if (out_if.byte_index !== want.byte_index)
          report_mismatch("byte_index", want.byte_index, out_if.byte_index);
        if (out_if.frame_length !== want.frame_length)
          report_mismatch("frame_length", want.frame_length, out_if.frame_length);
      end
    end
  end

  // hang guard
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_count,
             awaited_results.size());
    $display("tb_delimited_frame_length_checker_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    // every input known from time zero
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.rx_byte    = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.idx       = '0;
    cfg_if.wdata     = '0;
    recv_hold_cycles = 0;
    error_count      = 0;
    results_checked  = 0;
    counted_items    = 0;
    cur_start        = dflc_pkg::START_DELIM_RST;
    cur_end          = dflc_pkg::END_DELIM_RST;
    trk_in_frame     = 1'b0;
    {trk_count, trk_declared, trk_bad_field} = '0;
    foreach (status_tally[i]) status_tally[i] = 0;

    // sender idles little, receiver a lot
    send_idle_pct = 18;
    recv_idle_pct = 65;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_random_frames(300);

    // other way round
    send_idle_pct = 65;
    recv_idle_pct = 18;
    test_equal_delimiters();
    test_extreme_delimiters();

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_delimiters();
    test_backpressure();
    test_max_declared_length();

    // everything owed has arrived, then look for stray extra transactions
    wait_until_drained();
    repeat (10) @(posedge clk);

    $display("checked %0d result transactions over three idle mixes and five delimiter pairs",
             results_checked);
    $display("good %0d, too short %0d, mismatch %0d, restarts %0d, dropped bytes %0d",
             status_tally[dflc_pkg::ST_GOOD], status_tally[dflc_pkg::ST_SHORT],
             status_tally[dflc_pkg::ST_MISMATCH], status_tally[dflc_pkg::ST_RESTART],
             status_tally[dflc_pkg::ST_DROPPED]);
    if (error_count == 0) begin
      $display("tb_delimited_frame_length_checker_top: done, clean");
    end else begin
      $display("tb_delimited_frame_length_checker_top: done, errors");
    end
    $finish;
  end

endmodule
